// ===== design/owq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package owq_pkg;

  localparam int ID_W           = 4;
  localparam int KEY_W          = 64;
  localparam int NODE_COUNT_DEF = 16;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_POP    = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch request, read stored key
    logic apply;    // update slots, flags and result
  } owq_cmd_t;

endpackage

`default_nettype wire

// ===== design/owq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owq_ctrl
  import owq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output owq_cmd_t      cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  logic   accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd_o.capture = accept;
  assign cmd_o.apply   = (state_q == ST_EXEC);
  assign out_valid_o   = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/owq_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owq_dp
  import owq_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire owq_cmd_t          cmd_i,
  input  wire logic [1:0]        mode_i,
  input  wire logic [ID_W-1:0]   node_id_i,
  input  wire logic [KEY_W-1:0]  key_i,
  output logic                   ok_o,
  output logic [ID_W-1:0]        popped_node_o,
  output logic                   is_empty_o
);

  localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int OCC_W = $clog2(NODE_COUNT + 1);
  localparam int EXT_W = IDX_W + ID_W;

  // request
  mode_e              req_mode_q;
  logic [ID_W-1:0]    req_id_q;
  logic [KEY_W-1:0]   req_key_q;

  // per-node key store
  logic [KEY_W-1:0]   key_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] key_vld_q;
  logic [KEY_W-1:0]   key_rd_q;
  logic               key_rd_vld_q;

  // ordered slot row
  logic [ID_W-1:0]    slot_id_q  [NODE_COUNT];
  logic [KEY_W-1:0]   slot_key_q [NODE_COUNT];
  logic [OCC_W-1:0]   occ_q;
  logic [NODE_COUNT-1:0] queued_q;

  logic               ok_q;
  logic [ID_W-1:0]    popped_q;
  logic               empty_q;

  logic [EXT_W-1:0]   in_ext, req_ext, head_ext;
  logic [IDX_W-1:0]   in_idx, req_idx, head_idx;
  logic               id_ok, queued, full, op_ok;
  logic [OCC_W-1:0]   occ_d;
  logic [KEY_W-1:0]   push_key;

  logic [NODE_COUNT-1:0] live, stop, hit, rm_hit, ahead, after, tail;

  assign in_ext   = {{IDX_W{1'b0}}, node_id_i};
  assign req_ext  = {{IDX_W{1'b0}}, req_id_q};
  assign head_ext = {{IDX_W{1'b0}}, slot_id_q[0]};
  assign in_idx   = in_ext[IDX_W-1:0];
  assign req_idx  = req_ext[IDX_W-1:0];
  assign head_idx = head_ext[IDX_W-1:0];

  assign id_ok    = (EXT_W + 1)'(req_id_q) < (EXT_W + 1)'(NODE_COUNT);
  assign queued   = queued_q[req_idx];
  assign full     = (occ_q == OCC_W'(NODE_COUNT));
  assign push_key = key_rd_vld_q ? key_rd_q : '0;
  assign rm_hit   = (req_mode_q == MODE_POP) ? NODE_COUNT'(1) : hit;

  always_comb begin
    case (req_mode_q)
      MODE_PUSH, MODE_INSERT: op_ok = id_ok && !queued && !full;
      MODE_POP:               op_ok = (occ_q != '0);
      MODE_REMOVE:            op_ok = id_ok && queued && (|hit);
      default:                op_ok = 1'b0;
    endcase
  end

  always_comb begin
    occ_d = occ_q;
    if (op_ok) begin
      case (req_mode_q)
        MODE_PUSH, MODE_INSERT: occ_d = occ_q + OCC_W'(1);
        MODE_POP, MODE_REMOVE:  occ_d = occ_q - OCC_W'(1);
        default:                occ_d = occ_q;
      endcase
    end
  end

  // request capture and stored-key read
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_mode_q <= mode_e'(mode_i);
      req_id_q   <= node_id_i;
      req_key_q  <= key_i;
      key_rd_q   <= key_mem[in_idx];
    end
    if (cmd_i.apply && op_ok && (req_mode_q == MODE_INSERT)) begin
      key_mem[req_idx] <= req_key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_vld_q    <= '0;
      key_rd_vld_q <= 1'b0;
      queued_q     <= '0;
      occ_q        <= '0;
    end else begin
      if (cmd_i.capture) begin
        key_rd_vld_q <= key_vld_q[in_idx];
      end
      if (cmd_i.apply && op_ok) begin
        occ_q <= occ_d;
        case (req_mode_q)
          MODE_PUSH: begin
            queued_q[req_idx] <= 1'b1;
          end
          MODE_INSERT: begin
            queued_q[req_idx]  <= 1'b1;
            key_vld_q[req_idx] <= 1'b1;
          end
          MODE_POP: begin
            queued_q[head_idx] <= 1'b0;
          end
          MODE_REMOVE: begin
            queued_q[req_idx] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // slot cells: compare, locate and shift in one step
  for (genvar g = 0; g < NODE_COUNT; g++) begin : g_cell
    logic [ID_W-1:0]  left_id, right_id;
    logic [KEY_W-1:0] left_key, right_key;

    assign live[g] = OCC_W'(g) < occ_q;
    assign stop[g] = !live[g] || (slot_key_q[g] > req_key_q);
    assign hit[g]  = live[g] && (slot_id_q[g] == req_id_q);
    assign tail[g] = (OCC_W'(g) == occ_q);

    if (g == 0) begin : g_first
      assign ahead[g]  = 1'b1;
      assign after[g]  = rm_hit[0];
      assign left_id   = slot_id_q[g];
      assign left_key  = slot_key_q[g];
    end else begin : g_rest
      assign ahead[g]  = ~|stop[g-1:0];
      assign after[g]  = |rm_hit[g:0];
      assign left_id   = slot_id_q[g-1];
      assign left_key  = slot_key_q[g-1];
    end

    if (g == NODE_COUNT - 1) begin : g_last
      assign right_id  = slot_id_q[g];
      assign right_key = slot_key_q[g];
    end else begin : g_inner
      assign right_id  = slot_id_q[g+1];
      assign right_key = slot_key_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.apply && op_ok) begin
        case (req_mode_q)
          MODE_PUSH: begin
            if (tail[g]) begin
              slot_id_q[g]  <= req_id_q;
              slot_key_q[g] <= push_key;
            end
          end
          MODE_INSERT: begin
            if (!ahead[g]) begin
              slot_id_q[g]  <= left_id;
              slot_key_q[g] <= left_key;
            end else if (stop[g]) begin
              slot_id_q[g]  <= req_id_q;
              slot_key_q[g] <= req_key_q;
            end
          end
          default: begin
            if (after[g]) begin
              slot_id_q[g]  <= right_id;
              slot_key_q[g] <= right_key;
            end
          end
        endcase
      end
    end
  end

  // result beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      ok_q     <= op_ok;
      popped_q <= (op_ok && (req_mode_q == MODE_POP)) ? slot_id_q[0] : '0;
      empty_q  <= (occ_d == '0);
    end
  end

  assign ok_o          = ok_q;
  assign popped_node_o = popped_q;
  assign is_empty_o    = empty_q;

endmodule

`default_nettype wire

// ===== design/ordered_wait_queue.sv =====
// Ordered wait queue of node ids.
// Input channel: in_valid_i / in_stall_o carry one request beat (mode_i, node_id_i,
// key_i): push to tail, ordered insert by key (ties stay first-in first-out),
// pop head, or remove a named node.
// Output channel: out_valid_o / out_stall_i carry one result beat per request
// (ok_o, popped_node_o, is_empty_o).
// A request accepted in ST_IDLE is applied in ST_EXEC, which registers its result
// beat; no new request is taken meanwhile. Accept reads the node's stored key from
// the key memory, ST_EXEC runs the compare-and-shift slot row.
// The result sits in an output register; the next request is taken as soon as
// that register is free or drains in the same cycle.
// While the receiver stalls, the result beat holds and in_stall_o stays high
// once a new request would need the output register.
// Reset empties the queue, clears all queued flags and makes every stored
// key read as zero; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module ordered_wait_queue
  import owq_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [ID_W-1:0]   node_id_i,
  input  wire logic [KEY_W-1:0]  key_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   ok_o,
  output logic [ID_W-1:0]        popped_node_o,
  output logic                   is_empty_o
);

  owq_cmd_t cmd;

  owq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  owq_dp #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mode_i        (mode_i),
    .node_id_i     (node_id_i),
    .key_i         (key_i),
    .ok_o          (ok_o),
    .popped_node_o (popped_node_o),
    .is_empty_o    (is_empty_o)
  );

endmodule

`default_nettype wire

// ===== design/owq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owq_checker
  import owq_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic [1:0]        mode_i,
  input wire logic [ID_W-1:0]   node_id_i,
  input wire logic [KEY_W-1:0]  key_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              ok_o,
  input wire logic [ID_W-1:0]   popped_node_o,
  input wire logic              is_empty_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request accepted while previous one in flight");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ##1 out_valid_o)
    else $error("result beat missing two cycles after accept");

  a_fail_no_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (popped_node_o == '0))
    else $error("failed request reports a popped node");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(ok_o) && $stable(popped_node_o) && $stable(is_empty_o)))
    else $error("stalled result beat changed");

endmodule

bind ordered_wait_queue owq_checker u_owq_checker (.*);

`default_nettype wire
